FILE: src/ppmfd_pkg.sv
package ppmfd_pkg;

  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned REG_SEL_W  = 3;

  // register indexes (byte address = 4 * index)
  localparam logic [REG_SEL_W-1:0] REG_SYNC_THRESHOLD   = 3'd0;
  localparam logic [REG_SEL_W-1:0] REG_THROTTLE_MIN     = 3'd1;
  localparam logic [REG_SEL_W-1:0] REG_THROTTLE_MAX     = 3'd2;
  localparam logic [REG_SEL_W-1:0] REG_LINK_TIMEOUT     = 3'd3;
  localparam logic [REG_SEL_W-1:0] REG_THROTTLE_CHANNEL = 3'd4;

  localparam logic [15:0] RST_SYNC_THRESHOLD   = 16'd2100;
  localparam logic [15:0] RST_THROTTLE_MIN     = 16'd950;
  localparam logic [15:0] RST_THROTTLE_MAX     = 16'd2100;
  localparam logic [15:0] RST_LINK_TIMEOUT     = 16'd1000;
  localparam logic [3:0]  RST_THROTTLE_CHANNEL = 4'd2;

  localparam logic [15:0] TICKS_MAX = 16'hFFFF;

  typedef struct packed {
    logic [15:0] sync_threshold;
    logic [15:0] throttle_min;
    logic [15:0] throttle_max;
    logic [15:0] link_timeout;
    logic [3:0]  throttle_channel;
  } cfg_t;

  // last member lands in the lowest bits
  typedef struct packed {
    logic [15:0] channel_value;
    logic [3:0]  channel_index;
    logic        stored;
    logic        frame_end;
    logic        invalid_pulse;
    logic        link_ok;
  } result_t;

  localparam int unsigned RESULT_W = $bits(result_t);

endpackage

FILE: src/ppmfd_cfg.sv
module ppmfd_cfg
  import ppmfd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic                 wr_en;
  logic [REG_SEL_W-1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = paddr[CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_threshold   <= RST_SYNC_THRESHOLD;
      cfg.throttle_min     <= RST_THROTTLE_MIN;
      cfg.throttle_max     <= RST_THROTTLE_MAX;
      cfg.link_timeout     <= RST_LINK_TIMEOUT;
      cfg.throttle_channel <= RST_THROTTLE_CHANNEL;
    end else if (wr_en) begin
      case (reg_sel)
        REG_SYNC_THRESHOLD:   cfg.sync_threshold   <= pwdata[15:0];
        REG_THROTTLE_MIN:     cfg.throttle_min     <= pwdata[15:0];
        REG_THROTTLE_MAX:     cfg.throttle_max     <= pwdata[15:0];
        REG_LINK_TIMEOUT:     cfg.link_timeout     <= pwdata[15:0];
        REG_THROTTLE_CHANNEL: cfg.throttle_channel <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_SYNC_THRESHOLD:   prdata = {16'd0, cfg.sync_threshold};
      REG_THROTTLE_MIN:     prdata = {16'd0, cfg.throttle_min};
      REG_THROTTLE_MAX:     prdata = {16'd0, cfg.throttle_max};
      REG_LINK_TIMEOUT:     prdata = {16'd0, cfg.link_timeout};
      REG_THROTTLE_CHANNEL: prdata = {28'd0, cfg.throttle_channel};
      default:              prdata = 32'd0;
    endcase
  end

endmodule

FILE: src/ppmfd_core.sv
module ppmfd_core
  import ppmfd_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        beat,
  input  logic        kind,
  input  logic [15:0] pulse_width,
  input  cfg_t        cfg,
  output result_t     result
);

  localparam int unsigned IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned CNT_W = $clog2(NUM_CHANNELS + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(NUM_CHANNELS);

  logic [15:0]      channel_store [NUM_CHANNELS];
  logic [CNT_W-1:0] slot_index;
  logic             link_flag;
  logic             invalid_flag;
  logic [15:0]      elapsed_ticks;

  logic [CNT_W-1:0] slot_index_next;
  logic             link_flag_next;
  logic             invalid_flag_next;
  logic [15:0]      elapsed_ticks_next;
  logic             is_sync;
  logic             do_store;
  logic [15:0]      thr;

  assign is_sync  = !kind && (pulse_width >= cfg.sync_threshold);
  assign do_store = !kind && !is_sync && (slot_index < CNT_FULL);

  // throttle slot past the channel count reads as zero
  always_comb begin
    if (32'(cfg.throttle_channel) < NUM_CHANNELS) begin
      thr = channel_store[cfg.throttle_channel[IDX_W-1:0]];
    end else begin
      thr = 16'd0;
    end
  end

  always_comb begin
    slot_index_next    = slot_index;
    link_flag_next     = link_flag;
    invalid_flag_next  = invalid_flag;
    elapsed_ticks_next = elapsed_ticks;
    if (is_sync) begin
      slot_index_next    = '0;
      link_flag_next     = 1'b1;
      invalid_flag_next  = (thr < cfg.throttle_min) || (thr > cfg.throttle_max);
      elapsed_ticks_next = 16'd0;
    end else if (do_store) begin
      slot_index_next = slot_index + CNT_W'(1);
    end else if (kind && (elapsed_ticks != TICKS_MAX)) begin
      elapsed_ticks_next = elapsed_ticks + 16'd1;
    end
    if (elapsed_ticks_next > cfg.link_timeout) begin
      link_flag_next = 1'b0;
    end
  end

  always_comb begin
    result.link_ok       = link_flag_next;
    result.invalid_pulse = invalid_flag_next;
    result.frame_end     = is_sync;
    result.stored        = do_store;
    result.channel_index = do_store ? 4'(slot_index) : 4'd0;
    result.channel_value = do_store ? pulse_width : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_index    <= '0;
      link_flag     <= 1'b0;
      invalid_flag  <= 1'b0;
      elapsed_ticks <= 16'd0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        channel_store[i] <= 16'd0;
      end
    end else if (beat) begin
      slot_index    <= slot_index_next;
      link_flag     <= link_flag_next;
      invalid_flag  <= invalid_flag_next;
      elapsed_ticks <= elapsed_ticks_next;
      if (do_store) begin
        channel_store[slot_index[IDX_W-1:0]] <= pulse_width;
      end
    end
  end

endmodule

FILE: src/ppmfd_skid.sv
module ppmfd_skid
  import ppmfd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [RESULT_W-1:0] din,
  output logic                ready,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [RESULT_W-1:0] dout
);

  logic                skid_valid;
  logic [RESULT_W-1:0] skid;
  logic                pop;

  assign pop   = out_valid & out_ready;
  assign ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      dout <= skid_valid ? skid : din;
    end else if (push) begin
      skid <= din;
    end
  end

endmodule

FILE: src/ppm_frame_decoder_link_monitor.sv
// Channel   | Direction | Handshake                 | Payload
// s_axis    | in        | s_tvalid / s_tready       | s_tuser = kind, s_tdata = pulse width
// m_axis    | out       | m_tvalid / m_tready       | m_tdata = link/frame flags, slot, value
// apb       | in        | psel, penable, pready     | paddr, pwdata, prdata (5 registers)
//
// One beat per cycle in and out while neither side stalls; results are registered.
// Decode state is updated at the input beat from the registered state and config.
// A two-entry output buffer (result register plus skid) keeps s_tready high after
// m_tready drops until the skid fills; it falls only once both entries hold results.
// rst is synchronous: clears the decode state, channel slots, config to defaults.
module ppm_frame_decoder_link_monitor
  import ppmfd_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  // input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [15:0]           s_tdata,   // [15:0] pulse_width
  input  logic                  s_tuser,   // [0] kind: 0 pulse width, 1 ms tick
  // result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [23:0]           m_tdata,   // [0] link_ok [1] invalid_pulse [2] frame_end
                                           // [3] stored [7:4] channel_index
                                           // [23:8] channel_value
  // config
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_t    cfg;
  result_t result;
  logic    in_beat;

  assign in_beat = s_tvalid & s_tready;

  ppmfd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // decode step: state and channel slots update at the input beat
  ppmfd_core #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .beat        (in_beat),
    .kind        (s_tuser),
    .pulse_width (s_tdata),
    .cfg         (cfg),
    .result      (result)
  );

  // result register plus skid entry
  ppmfd_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (in_beat),
    .din       (result),
    .ready     (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .dout      (m_tdata)
  );

`ifndef SYNTH
  // every accepted beat leaves a result waiting next cycle
  a_beat_to_result: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> m_tvalid)
    else $error("input beat produced no result");

  // a sync never writes a slot
  a_sync_not_stored: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[2] && m_tdata[3]))
    else $error("frame end and store in one result");

  // sync clears the tick count, so the link is up after it
  a_sync_link_up: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[2]) |-> m_tdata[0])
    else $error("link down on a frame end");

  // slot fields are zero when nothing was stored
  a_idle_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[3]) |-> (m_tdata[23:4] == 20'd0))
    else $error("slot fields set without a store");
`endif

endmodule
